// ===== src/tpsq_pkg.sv =====
// Package for the three-class priority service queue.
// Holds the shared types, codes and default sizes; used by every module of the block.
`default_nettype none

package tpsq_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_FIFO_DEPTH = 16;
  localparam int DEF_KEY_BITS   = 7;
  localparam int DEF_TIME_BITS  = 10;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SHIFT_W    = 16;
  // The tick counter stops one past the shift length, so it needs one more bit.
  localparam int TICK_W     = SHIFT_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_LENGTH     = 2'd2;

  localparam int MIDDLE_THRESHOLD_RESET = 60;
  localparam int TOP_THRESHOLD_RESET    = 80;
  localparam int SHIFT_LENGTH_RESET     = 180;

  // Request opcodes.
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Result status codes.
  localparam logic ST_SERVED  = 1'b0;
  localparam logic ST_DROPPED = 1'b1;

  localparam int NUM_CLASSES = 3;

  typedef enum logic [1:0] {
    CLS_REGULAR = 2'd0,
    CLS_MIDDLE  = 2'd1,
    CLS_TOP     = 2'd2
  } class_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SERVE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted request
    logic push;        // write the arrival into its class FIFO
    logic load_drop;   // put a drop result into the output register
    logic pop_read;    // read the head of the highest non-empty class
    logic pop_commit;  // retire that head and put it into the output register
    logic tick_done;   // count the timer down and advance the tick counter
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic after_shift;
    logic is_tick;
    logic target_full;
    logic server_busy;
    logic any_queued;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/tpsq_ctrl.sv =====
// Controller state machine of the three-class priority service queue.
// Depends on tpsq_pkg for the state, command and status types.
`default_nettype none

module tpsq_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire tpsq_pkg::dp_status_t   status,
  output tpsq_pkg::dp_cmd_t           cmd
);
  import tpsq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (status.after_shift) begin
          state_next = S_IDLE;
        end else if (!status.is_tick) begin
          // A drop has to wait until the output register can take it.
          if (!status.target_full) begin
            cmd.push   = 1'b1;
            state_next = S_IDLE;
          end else if (status.out_free) begin
            cmd.load_drop = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (!status.server_busy && status.any_queued) begin
          cmd.pop_read = 1'b1;
          state_next   = S_SERVE;
        end else begin
          cmd.tick_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SERVE: begin
        if (status.out_free) begin
          cmd.pop_commit = 1'b1;
          cmd.tick_done  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tpsq_datapath.sv =====
// Datapath of the three-class priority service queue: class FIFOs, pointers,
// service timer, tick counter, configuration registers and output register.
// Depends on tpsq_pkg.
`default_nettype none

module tpsq_datapath #(
  parameter int FIFO_DEPTH = tpsq_pkg::DEF_FIFO_DEPTH,
  parameter int KEY_BITS   = tpsq_pkg::DEF_KEY_BITS,
  parameter int TIME_BITS  = tpsq_pkg::DEF_TIME_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            opcode,
  input  wire logic [KEY_BITS-1:0]             age,
  input  wire logic [TIME_BITS-1:0]            svc_time,
  input  wire logic                            out_stall,
  output logic                                 out_valid,
  output logic                                 status,
  output logic [KEY_BITS-1:0]                  served_age,
  output logic [TIME_BITS-1:0]                 served_time,
  output logic [1:0]                           served_class,
  input  wire logic                            cfg_we,
  input  wire logic [tpsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpsq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire tpsq_pkg::dp_cmd_t               cmd,
  output tpsq_pkg::dp_status_t                 dp_status
);
  import tpsq_pkg::*;

  localparam int IDX_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W   = IDX_W + 1;
  localparam int ENTRY_W = KEY_BITS + TIME_BITS;

  // Configuration registers.
  logic [KEY_BITS-1:0] middle_threshold;
  logic [KEY_BITS-1:0] top_threshold;
  logic [SHIFT_W-1:0]  shift_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      middle_threshold <= KEY_BITS'(MIDDLE_THRESHOLD_RESET);
      top_threshold    <= KEY_BITS'(TOP_THRESHOLD_RESET);
      shift_length     <= SHIFT_W'(SHIFT_LENGTH_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIDDLE_THRESHOLD: middle_threshold <= cfg_data[KEY_BITS-1:0];
        REG_TOP_THRESHOLD:    top_threshold    <= cfg_data[KEY_BITS-1:0];
        REG_SHIFT_LENGTH:     shift_length     <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured request.
  logic                 item_op;
  logic [KEY_BITS-1:0]  item_age;
  logic [TIME_BITS-1:0] item_time;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op   <= opcode;
      item_age  <= age;
      item_time <= svc_time;
    end
  end

  // The regular test is made first, so crossed thresholds still sort the same way.
  class_t target_cls;
  always_comb begin
    priority if (item_age < middle_threshold) begin
      target_cls = CLS_REGULAR;
    end else if (item_age < top_threshold) begin
      target_cls = CLS_MIDDLE;
    end else begin
      target_cls = CLS_TOP;
    end
  end

  // FIFO pointers, one head and fill count per class.
  logic [IDX_W-1:0] head  [NUM_CLASSES];
  logic [CNT_W-1:0] count [NUM_CLASSES];
  logic [IDX_W-1:0] tail_vec [NUM_CLASSES];
  logic [IDX_W-1:0] head_next_vec [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] full_vec;
  logic [NUM_CLASSES-1:0] nonempty_vec;

  always_comb begin
    logic [SUM_W-1:0] sum;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      sum = SUM_W'(head[c]) + SUM_W'(count[c]);
      tail_vec[c] = (sum >= SUM_W'(FIFO_DEPTH)) ? IDX_W'(sum - SUM_W'(FIFO_DEPTH))
                                                : IDX_W'(sum);
      head_next_vec[c] = (head[c] == IDX_W'(FIFO_DEPTH - 1)) ? '0
                                                             : head[c] + IDX_W'(1);
      full_vec[c]     = (count[c] == CNT_W'(FIFO_DEPTH));
      nonempty_vec[c] = (count[c] != '0);
    end
  end

  class_t serve_cls;
  always_comb begin
    priority if (nonempty_vec[CLS_TOP]) begin
      serve_cls = CLS_TOP;
    end else if (nonempty_vec[CLS_MIDDLE]) begin
      serve_cls = CLS_MIDDLE;
    end else begin
      serve_cls = CLS_REGULAR;
    end
  end

  class_t rd_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c]  <= '0;
        count[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (cmd.push && target_cls == class_t'(c)) begin
          count[c] <= count[c] + CNT_W'(1);
        end else if (cmd.pop_commit && rd_cls == class_t'(c)) begin
          head[c]  <= head_next_vec[c];
          count[c] <= count[c] - CNT_W'(1);
        end
      end
    end
  end

  // Entry storage: one write and one registered read per cycle.
  logic [ENTRY_W-1:0] mem [NUM_CLASSES][FIFO_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[target_cls][tail_vec[target_cls]] <= {item_age, item_time};
    end
    if (cmd.pop_read) begin
      rd_data <= mem[serve_cls][head[serve_cls]];
      rd_cls  <= serve_cls;
    end
  end

  logic [KEY_BITS-1:0]  rd_age;
  logic [TIME_BITS-1:0] rd_time;
  assign {rd_age, rd_time} = rd_data;

  // Service timer and tick counter.
  logic [TIME_BITS-1:0] busy_ticks_left;
  logic [TIME_BITS-1:0] busy_base;
  logic [TICK_W-1:0]    tick_count;

  // A newly served entry loads the timer, which then counts this tick at once.
  assign busy_base = cmd.pop_commit ? rd_time : busy_ticks_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_ticks_left <= '0;
      tick_count      <= '0;
    end else if (cmd.tick_done) begin
      busy_ticks_left <= (busy_base != '0) ? busy_base - TIME_BITS'(1) : '0;
      tick_count      <= tick_count + TICK_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_drop || cmd.pop_commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_drop) begin
      status       <= ST_DROPPED;
      served_age   <= item_age;
      served_time  <= item_time;
      served_class <= target_cls;
    end else if (cmd.pop_commit) begin
      status       <= ST_SERVED;
      served_age   <= rd_age;
      served_time  <= rd_time;
      served_class <= rd_cls;
    end
  end

  always_comb begin
    dp_status.after_shift = (tick_count > TICK_W'(shift_length));
    dp_status.is_tick     = (item_op == OP_TICK);
    dp_status.target_full = full_vec[target_cls];
    dp_status.server_busy = (busy_ticks_left != '0);
    dp_status.any_queued  = |nonempty_vec;
    dp_status.out_free    = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== src/three_class_priority_service_queue.sv =====
// Top level of the three-class priority service queue: controller plus datapath.
// Depends on tpsq_pkg, tpsq_ctrl and tpsq_datapath.
//
//   channel   direction  handshake             contents
//   in        request    in_valid / in_stall   opcode, age, svc_time
//   out       result     out_valid / out_stall status, served_age, served_time, served_class
//   cfg       write      cfg_we                cfg_index, cfg_data
//
// An arrival, an ignored request and a tick that serves nothing pass through S_IDLE
// and S_EXEC; a tick that serves an entry also passes through S_SERVE, for the
// registered read of the entry store. A drop or a served entry waits in the controller
// while the output register still holds an unaccepted result.
// Reset is synchronous; all FIFOs come out empty, with no clearing pass.
`default_nettype none

module three_class_priority_service_queue #(
  parameter int FIFO_DEPTH = tpsq_pkg::DEF_FIFO_DEPTH,
  parameter int KEY_BITS   = tpsq_pkg::DEF_KEY_BITS,
  parameter int TIME_BITS  = tpsq_pkg::DEF_TIME_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            opcode,
  input  wire logic [KEY_BITS-1:0]             age,
  input  wire logic [TIME_BITS-1:0]            svc_time,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 status,
  output logic [KEY_BITS-1:0]                  served_age,
  output logic [TIME_BITS-1:0]                 served_time,
  output logic [1:0]                           served_class,
  input  wire logic                            cfg_we,
  input  wire logic [tpsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpsq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tpsq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;

  tpsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (cmd)
  );

  tpsq_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .opcode       (opcode),
    .age          (age),
    .svc_time     (svc_time),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .served_age   (served_age),
    .served_time  (served_time),
    .served_class (served_class),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .dp_status    (dp_status)
  );

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another was in flight");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !dp_status.target_full && !dp_status.after_shift)
    else $error("push into a full FIFO or after the shift");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_read |-> dp_status.any_queued && !dp_status.server_busy)
    else $error("head read while the server is busy or all FIFOs are empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_drop || cmd.pop_commit) |-> dp_status.out_free)
    else $error("result loaded over an unaccepted result");

endmodule

`default_nettype wire
